/* hw/rtl/scsd_pkg.sv */
// Shared types, constants and segment encoding for the serial command
// seven-segment driver. No dependencies.

package scsd_pkg;

	// characters counted per line and the width of the line position counter
	localparam int unsigned LINE_LENGTH = 10;
	localparam int unsigned IDX_W       = $clog2(LINE_LENGTH + 1);

	// number of fields held from a line
	localparam int unsigned KEPT_FIELDS = 3;
	localparam int unsigned NUM_POS     = 4;

	// character codes
	localparam logic [7:0] CHAR_LF   = 8'h0a;
	localparam logic [7:0] CHAR_CR   = 8'h0d;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	// stored field codes ('A' and 'a' minus '0')
	localparam logic [7:0] CODE_ALL_UPPER = 8'd17;
	localparam logic [7:0] CODE_ALL_LOWER = 8'd49;
	localparam logic [7:0] SW_OFF         = 8'd0;
	localparam logic [7:0] SW_ON          = 8'd1;
	localparam logic [7:0] BLANK_VALUE    = 8'd10;

	// field positions in the line
	localparam logic [1:0] FLD_POS = 2'd0;
	localparam logic [1:0] FLD_VAL = 2'd1;
	localparam logic [1:0] FLD_SW  = 2'd2;

	typedef logic [7:0] seg_t;

	// one result of a received character
	typedef struct packed {
		logic [7:0] echo_byte;
		seg_t [NUM_POS-1:0] seg;
		logic [NUM_POS-1:0] pos_enables;
		logic line_done;
		logic err_switch;
		logic err_position;
		logic err_value;
	} result_t;

	// active-low segment pattern of a shown value, blank for 10 and above
	function automatic seg_t seg_pattern(input logic [3:0] v);
		seg_t p;
		begin
			unique case (v)
				4'd0: p = 8'h03;
				4'd1: p = 8'h9f;
				4'd2: p = 8'h25;
				4'd3: p = 8'h0d;
				4'd4: p = 8'h99;
				4'd5: p = 8'h49;
				4'd6: p = 8'h41;
				4'd7: p = 8'h1f;
				4'd8: p = 8'h01;
				4'd9: p = 8'h09;
				default: p = 8'hff;
			endcase
			return p;
		end
	endfunction

endpackage

/* hw/rtl/serial_command_seven_segment_driver_top.sv */
// Top level of the serial command seven-segment driver: input register,
// decoder core and result register. Depends on scsd_pkg and scsd_core.

// One request carries one received character and produces exactly one
// result: the echoed character, the four active-low segment patterns, the
// sticky position enables and, on a line feed or carriage return, the line
// decode flags. The block takes one character per clock cycle unless a
// stalled result holds it back; each request passes through the input
// register, then the decoder and the result register. A stalled result
// holds the input register, and a new request is still taken while the
// result register waits if the input register is free.

module serial_command_seven_segment_driver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] echo_byte,
	output logic [7:0] seg_pos0,
	output logic [7:0] seg_pos1,
	output logic [7:0] seg_pos2,
	output logic [7:0] seg_pos3,
	output logic [3:0] pos_enables,
	output logic       line_done,
	output logic       err_switch,
	output logic       err_position,
	output logic       err_value
);

	logic              valid_s1;
	logic [7:0]        rx_s1;
	logic              out_valid_q;
	scsd_pkg::result_t result_q;
	scsd_pkg::result_t result_d;
	logic              advance;
	logic              in_accept;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_s1 <= rx_byte;
		end
	end

	// decoder and state
	scsd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_s1),
		.result  (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	// outputs
	assign out_valid    = out_valid_q;
	assign echo_byte    = result_q.echo_byte;
	assign seg_pos0     = result_q.seg[0];
	assign seg_pos1     = result_q.seg[1];
	assign seg_pos2     = result_q.seg[2];
	assign seg_pos3     = result_q.seg[3];
	assign pos_enables  = result_q.pos_enables;
	assign line_done    = result_q.line_done;
	assign err_switch   = result_q.err_switch;
	assign err_position = result_q.err_position;
	assign err_value    = result_q.err_value;

endmodule

/* hw/rtl/scsd_core.sv */
// Line collector and command decoder: holds the line fields, position
// counter, shown values and enables. Depends on scsd_pkg.

module scsd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output scsd_pkg::result_t     result
);

	logic [7:0]                      field_q [scsd_pkg::KEPT_FIELDS];
	logic [7:0]                      field_d [scsd_pkg::KEPT_FIELDS];
	logic [scsd_pkg::IDX_W-1:0]      widx_q;
	logic [scsd_pkg::IDX_W-1:0]      widx_d;
	logic [3:0]                      shown_q [scsd_pkg::NUM_POS];
	logic [3:0]                      shown_d [scsd_pkg::NUM_POS];
	logic [scsd_pkg::NUM_POS-1:0]    enable_q;
	logic [scsd_pkg::NUM_POS-1:0]    enable_d;

	logic       term;
	logic       widx_kept;
	logic [7:0] pos;
	logic [7:0] val;
	logic [7:0] sw;
	logic       all_pos;
	logic       single_pos;
	logic       e_sw;
	logic       e_pos;
	logic       e_val;

	assign term      = (rx_byte == scsd_pkg::CHAR_LF) || (rx_byte == scsd_pkg::CHAR_CR);
	assign widx_kept = widx_q < scsd_pkg::IDX_W'(scsd_pkg::KEPT_FIELDS);

	// next state for this character
	always_comb begin
		field_d  = field_q;
		widx_d   = widx_q;
		shown_d  = shown_q;
		enable_d = enable_q;
		e_sw     = 1'b0;
		e_pos    = 1'b0;
		e_val    = 1'b0;
		pos      = '0;
		val      = '0;
		sw       = '0;
		all_pos    = 1'b0;
		single_pos = 1'b0;
		if (term) begin
			// short line clears the field at the current position
			if (widx_kept) begin
				field_d[widx_q[1:0]] = '0;
			end
			pos = field_d[scsd_pkg::FLD_POS];
			val = field_d[scsd_pkg::FLD_VAL];
			sw  = field_d[scsd_pkg::FLD_SW];
			if (sw == scsd_pkg::SW_OFF) begin
				val = scsd_pkg::BLANK_VALUE;
				field_d[scsd_pkg::FLD_VAL] = scsd_pkg::BLANK_VALUE;
			end else if (sw != scsd_pkg::SW_ON) begin
				e_sw = 1'b1;
			end
			all_pos    = (pos == scsd_pkg::CODE_ALL_UPPER) ||
			             (pos == scsd_pkg::CODE_ALL_LOWER);
			single_pos = pos < 8'(scsd_pkg::NUM_POS);
			// sticky enables
			if (all_pos) begin
				enable_d = '1;
			end else if (single_pos) begin
				enable_d[pos[1:0]] = 1'b1;
			end else begin
				e_pos = 1'b1;
			end
			// shown value update
			if (val <= scsd_pkg::BLANK_VALUE) begin
				for (int i = 0; i < scsd_pkg::NUM_POS; i++) begin
					if (all_pos || (single_pos && (pos[1:0] == 2'(i)))) begin
						shown_d[i] = val[3:0];
					end
				end
			end else begin
				e_val = 1'b1;
			end
			widx_d = '0;
		end else if (widx_q < scsd_pkg::IDX_W'(scsd_pkg::LINE_LENGTH)) begin
			if (widx_kept) begin
				field_d[widx_q[1:0]] = rx_byte - scsd_pkg::CHAR_ZERO;
			end
			widx_d = widx_q + scsd_pkg::IDX_W'(1);
		end
	end

	// result from the updated state
	always_comb begin
		result.echo_byte   = rx_byte;
		for (int i = 0; i < scsd_pkg::NUM_POS; i++) begin
			result.seg[i] = scsd_pkg::seg_pattern(shown_d[i]);
		end
		result.pos_enables  = enable_d;
		result.line_done    = term;
		result.err_switch   = e_sw;
		result.err_position = e_pos;
		result.err_value    = e_val;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scsd_pkg::KEPT_FIELDS; i++) begin
				field_q[i] <= '0;
			end
			for (int i = 0; i < scsd_pkg::NUM_POS; i++) begin
				shown_q[i] <= '0;
			end
			widx_q   <= '0;
			enable_q <= '0;
		end else if (step) begin
			field_q  <= field_d;
			shown_q  <= shown_d;
			widx_q   <= widx_d;
			enable_q <= enable_d;
		end
	end

endmodule
